>>> hdl/aesd_pkg.sv
package aesd_pkg;

    localparam int KeyWordsMax = 60;
    localparam int Stages = 15;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY_PART_0 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY_PART_1 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY_PART_2 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_KEY_PART_3 = 3'd4;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int r = 0; r < 4; r++) begin
            a[r] = col[31-8*r -: 8];
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
            m9[r] = x8[r] ^ a[r];
            mb[r] = x8[r] ^ x2[r] ^ a[r];
            md[r] = x8[r] ^ x4[r] ^ a[r];
            me[r] = x8[r] ^ x4[r] ^ x2[r];
        end
        inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                       m9[0] ^ me[1] ^ mb[2] ^ md[3],
                       md[0] ^ m9[1] ^ me[2] ^ mb[3],
                       mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

>>> hdl/aes_block_decrypt.sv
// Channel | Dir | Handshake            | Payload
// s_      | in  | s_tvalid / s_tready  | s_tdata: cipher_high, cipher_low
// m_      | out | m_tvalid / m_tready  | m_tdata: plain_high, plain_low
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
// Every word passes 15 register stages, one round each; a new word can enter every
// cycle unless stalled or busy; shorter keys pass the first stages unchanged.
// After reset and after each key write the schedule unit writes one key word per
// cycle (44, 52 or 60 words), and neither s_ nor cfg_ is ready during that time.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
module aes_block_decrypt
    import aesd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,   // cipher_high [63:0], cipher_low [127:64]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // plain_high [63:0], plain_low [127:64]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [1:0]   key_size_reg;
    logic [63:0]  key_part_reg [4];
    logic [31:0]  rk_reg [KeyWordsMax];
    logic [31:0]  win_reg [8];
    logic         busy_reg, busy_next;
    logic [5:0]   widx_reg;
    logic [2:0]   wmod_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;
    logic [31:0]  key_word;
    logic [31:0]  tmp_word;
    logic [31:0]  rot_word;
    logic [31:0]  far_word;
    logic [31:0]  new_word;
    logic         cfg_hit;

    logic [127:0] data_reg [Stages];
    logic         valid_reg [Stages];
    logic [127:0] data_next [Stages];
    logic         advance;

    assign nk = (key_size_reg == 2'd0) ? 4'd4 : (key_size_reg == 2'd1) ? 4'd6 : 4'd8;
    assign nr = nk + 4'd6;
    assign total = {nk, 2'b00} + 6'd28;
    assign cfg_ready = !busy_reg;
    assign cfg_hit = cfg_valid && cfg_ready && (cfg_index <= REG_KEY_PART_3);

    always_comb begin
        key_word = widx_reg[0] ? key_part_reg[widx_reg[2:1]][31:0]
                               : key_part_reg[widx_reg[2:1]][63:32];
        rot_word = {win_reg[7][23:0], win_reg[7][31:24]};
        tmp_word = win_reg[7];
        if (wmod_reg == 3'd0) begin
            tmp_word = {SBOX_FWD[rot_word[31:24]], SBOX_FWD[rot_word[23:16]],
                        SBOX_FWD[rot_word[15:8]], SBOX_FWD[rot_word[7:0]]}
                       ^ {rcon_reg, 24'd0};
        end else if (nk == 4'd8 && wmod_reg == 3'd4) begin
            tmp_word = {SBOX_FWD[win_reg[7][31:24]], SBOX_FWD[win_reg[7][23:16]],
                        SBOX_FWD[win_reg[7][15:8]], SBOX_FWD[win_reg[7][7:0]]};
        end
        case (nk)
            4'd4:    far_word = win_reg[4];
            4'd6:    far_word = win_reg[2];
            default: far_word = win_reg[0];
        endcase
        new_word = (widx_reg < {2'b00, nk}) ? key_word : (far_word ^ tmp_word);
        busy_next = busy_reg && (widx_reg != total - 6'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg <= 2'd0;
            for (int p = 0; p < 4; p++) key_part_reg[p] <= 64'd0;
            busy_reg <= 1'b1;
            widx_reg <= 6'd0;
            wmod_reg <= 3'd0;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            rk_reg[widx_reg] <= new_word;
            for (int w = 0; w < 7; w++) win_reg[w] <= win_reg[w+1];
            win_reg[7] <= new_word;
            busy_reg <= busy_next;
            widx_reg <= widx_reg + 6'd1;
            wmod_reg <= ({1'b0, wmod_reg} == nk - 4'd1) ? 3'd0 : wmod_reg + 3'd1;
            if (wmod_reg == 3'd0 && widx_reg >= {2'b00, nk}) begin
                rcon_reg <= xtime(rcon_reg);
            end
        end else if (cfg_hit) begin
            if (cfg_index == REG_KEY_SIZE) begin
                key_size_reg <= cfg_data[1:0];
            end else begin
                key_part_reg[2'(cfg_index - REG_KEY_PART_0)] <= cfg_data;
            end
            busy_reg <= 1'b1;
            widx_reg <= 6'd0;
            wmod_reg <= 3'd0;
            rcon_reg <= 8'h01;
        end
    end

    // Stage k works on round 14 - k.
    always_comb begin
        logic [127:0] din;
        logic [127:0] ss;
        logic [127:0] rk;
        logic [127:0] mixed;
        for (int k = 0; k < Stages; k++) begin
            din = (k == 0) ? {s_tdata[63:0], s_tdata[127:64]} : data_reg[k-1];
            rk = {rk_reg[4*(14-k)], rk_reg[4*(14-k)+1],
                  rk_reg[4*(14-k)+2], rk_reg[4*(14-k)+3]};
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    ss[127-32*c-8*r -: 8] = SBOX_INV[din[127-32*((c+4-r)%4)-8*r -: 8]];
                end
            end
            ss = ss ^ rk;
            for (int c = 0; c < 4; c++) begin
                mixed[127-32*c -: 32] = inv_mix_col(ss[127-32*c -: 32]);
            end
            if (4'(14 - k) > nr) begin
                data_next[k] = din;
            end else if (4'(14 - k) == nr) begin
                data_next[k] = din ^ rk;
            end else if (k == Stages - 1) begin
                data_next[k] = ss;
            end else begin
                data_next[k] = mixed;
            end
        end
    end

    assign advance = m_tready || !m_tvalid;
    assign s_tready = advance && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Stages; k++) valid_reg[k] <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_tvalid && s_tready;
            for (int k = 1; k < Stages; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < Stages; k++) data_reg[k] <= data_next[k];
        end
    end

    assign m_tvalid = valid_reg[Stages-1];
    assign m_tdata = {data_reg[Stages-1][63:0], data_reg[Stages-1][127:64]};

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready && !cfg_ready)
        else $error("input taken while key schedule runs");

    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> widx_reg < total)
        else $error("key schedule index past end");

    a_cfg_starts_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> busy_reg && widx_reg == 6'd0)
        else $error("key write did not restart schedule");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> m_tvalid && $stable(valid_reg[Stages-2]))
        else $error("pipeline moved during stall");

endmodule
